// ----- hdl/perlin_noise_3d_octaves_assert.svh -----
// Assertion macros for the checker file.
`ifndef PERLIN_NOISE_3D_OCTAVES_ASSERT_SVH
`define PERLIN_NOISE_3D_OCTAVES_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PN3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pn3_pkg.sv -----
package pn3_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam logic [3:0] HASH_LAST = 4'd13;
  localparam logic [3:0] HASH_GRAD_FIRST = 4'd6;
  localparam logic [2:0] LERP_LAST = 3'd6;
  localparam logic [1:0] FADE_LAST_STEP = 2'd3;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FADE,
    ST_HASH_RD,
    ST_HASH_WB,
    ST_LERP,
    ST_ACC
  } pn3_state_t;

  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PERM_AW-1:0] raddr;
  } pn3_mem_req_t;

endpackage

// ----- hdl/pn3_perm_ram.sv -----
module pn3_perm_ram
  import pn3_pkg::*;
(
  input  logic         clk,
  input  pn3_mem_req_t req,
  output logic [7:0]   rdata
);

  logic [7:0] mem [PERM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hdl/pn3_mul.sv -----
module pn3_mul
  import pn3_pkg::*;
#(
  parameter int MW = 21,
  parameter int FRAC_BITS = 16
) (
  input  logic signed [MW-1:0]             op_a,
  input  logic signed [MW-1:0]             op_b,
  output logic signed [2*MW-FRAC_BITS-1:0] res
);

  logic signed [2*MW-1:0] prod;

  // floor rescale: arithmetic shift rounds toward minus infinity
  assign prod = op_a * op_b;
  assign res  = prod[2*MW-1:FRAC_BITS];

endmodule

// ----- hdl/perlin_noise_3d_octaves.sv -----
// Improved 3D Perlin noise summed over octaves, unsigned fixed point.
// Usage: drive the in_ ports and pulse start while busy is low; the item
// is taken at that clock edge. in_mode 0 writes in_table_value into the
// permutation table at in_table_index; in_mode 1 evaluates octave noise
// at (in_coord_x, in_coord_y, in_coord_z), 8.FRAC_BITS fixed point.
// Every item yields one result: out_valid is high for exactly one cycle
// with out_noise_sum (Q1.FRAC_BITS, saturated; zero for a load item).
// A load item or zero octaves gives its result in the cycle after
// acceptance. An evaluation of n octaves (n capped at MAX_OCTAVES) does,
// per octave, 12 fade multiplies on the shared multiplier, 14 table
// reads (read, then write-back) on the single permutation RAM port, 7
// lerp multiplies and one accumulate. busy is high during that time and
// falls in the cycle out_valid is shown, so the next start may be taken
// at the edge that ends the result cycle. One item at a time.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// out_valid; the permutation table is not cleared and must be loaded
// before evaluation. The receiver cannot stall: results are not held.
module perlin_noise_3d_octaves
  import pn3_pkg::*;
#(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [7:0]              in_table_index,
  input  logic [7:0]              in_table_value,
  input  logic [8+FRAC_BITS-1:0]  in_coord_x,
  input  logic [8+FRAC_BITS-1:0]  in_coord_y,
  input  logic [8+FRAC_BITS-1:0]  in_coord_z,
  input  logic [3:0]              in_octave_count,
  output logic                    out_valid,
  output logic [FRAC_BITS:0]      out_noise_sum
);

  localparam int CW = 8 + FRAC_BITS;      // coordinate width
  localparam int LW = FRAC_BITS + 3;      // gradient / lerp value width
  localparam int AW = FRAC_BITS + 4;      // fade intermediate width
  localparam int MW = FRAC_BITS + 5;      // multiplier operand width
  localparam int RW = 2 * MW - FRAC_BITS; // rescaled product width
  localparam int SW = FRAC_BITS + 5;      // octave sum width
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam logic [FRAC_BITS:0] ONE_T = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] SUM_MAX = (SW'(1) << (FRAC_BITS + 1)) - SW'(1);

  // sequencer state and counters
  pn3_state_t state_r, state_nxt;
  logic [1:0]    fa_r, fa_nxt;       // fade axis
  logic [1:0]    fs_r, fs_nxt;       // fade Horner step
  logic [3:0]    hs_r, hs_nxt;       // hash read step
  logic [2:0]    lk_r, lk_nxt;       // lerp step
  logic [OW-1:0] oct_r, oct_nxt;
  logic [OW-1:0] noct_r, noct_nxt;
  logic          out_valid_r, out_valid_nxt;

  // datapath registers
  logic [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [FRAC_BITS:0] fade_r [3];
  logic [FRAC_BITS:0] fade_nxt [3];
  logic [7:0] ha_r, ha_nxt, hb_r, hb_nxt;
  logic [7:0] haa_r, haa_nxt, hab_r, hab_nxt, hba_r, hba_nxt, hbb_r, hbb_nxt;
  logic [7:0] gh_r [8];
  logic [7:0] gh_nxt [8];
  logic signed [LW-1:0] lv_r [6];
  logic signed [LW-1:0] lv_nxt [6];
  logic signed [LW-1:0] noise_r, noise_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [FRAC_BITS:0]   out_sum_r, out_sum_nxt;

  // shared units
  pn3_mem_req_t mem_req;
  logic [7:0]   mem_rdata;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [RW-1:0] mul_res;

  pn3_perm_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  pn3_mul #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_mul (
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  function automatic logic signed [LW-1:0] grad(
    input logic [7:0] hv,
    input logic signed [LW-1:0] x,
    input logic signed [LW-1:0] y,
    input logic signed [LW-1:0] z
  );
    logic [3:0] h;
    logic signed [LW-1:0] u, v;
    h = hv[3:0];
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // coordinate fields
  logic [7:0] ix, iy, iz;
  logic signed [LW-1:0] x0, x1, y0, y1, z0, z1;
  assign ix = cx_r[CW-1:FRAC_BITS];
  assign iy = cy_r[CW-1:FRAC_BITS];
  assign iz = cz_r[CW-1:FRAC_BITS];
  assign x0 = LW'(cx_r[FRAC_BITS-1:0]);
  assign y0 = LW'(cy_r[FRAC_BITS-1:0]);
  assign z0 = LW'(cz_r[FRAC_BITS-1:0]);
  assign x1 = x0 - LW'(ONE_T);
  assign y1 = y0 - LW'(ONE_T);
  assign z1 = z0 - LW'(ONE_T);

  logic [OW-1:0] noct_in;
  always_comb begin
    if (32'(in_octave_count) > MAX_OCTAVES) begin
      noct_in = OW'(MAX_OCTAVES);
    end else begin
      noct_in = OW'(in_octave_count);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_mode && (noct_in != '0)) begin
          state_nxt = ST_FADE;
        end
      end
      ST_FADE: begin
        if (fa_r == AXIS_LAST && fs_r == FADE_LAST_STEP) begin
          state_nxt = ST_HASH_RD;
        end
      end
      ST_HASH_RD: state_nxt = ST_HASH_WB;
      ST_HASH_WB: begin
        state_nxt = (hs_r == HASH_LAST) ? ST_LERP : ST_HASH_RD;
      end
      ST_LERP: begin
        if (lk_r == LERP_LAST) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = (oct_r + OW'(1) == noct_r) ? ST_IDLE : ST_FADE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fade operands
  logic [FRAC_BITS-1:0] tsel;
  logic [AW-1:0] a_calc, fade_op;
  logic [AW-1:0] fade_e;
  always_comb begin
    case (fa_r)
      2'd0:    tsel = cx_r[FRAC_BITS-1:0];
      2'd1:    tsel = cy_r[FRAC_BITS-1:0];
      default: tsel = cz_r[FRAC_BITS-1:0];
    endcase
    a_calc = (AW'(15) << FRAC_BITS) - ((AW'(tsel) << 2) + (AW'(tsel) << 1));
    case (fs_r)
      2'd0:    fade_op = a_calc;
      2'd1:    fade_op = (AW'(10) << FRAC_BITS) - acc_r;
      default: fade_op = acc_r;
    endcase
    fade_e = mul_res[AW-1:0];
  end

  // lerp operands
  logic signed [LW-1:0] la, lb;
  logic [FRAC_BITS:0]   lt;
  logic [7:0]           gha, ghb;
  logic signed [LW-1:0] ly, lz;
  logic signed [LW:0]   ldiff, lsum;
  always_comb begin
    gha = gh_r[{lk_r[1:0], 1'b0}];
    ghb = gh_r[{lk_r[1:0], 1'b1}];
    ly  = lk_r[0] ? y1 : y0;
    lz  = lk_r[1] ? z1 : z0;
    case (lk_r)
      3'd4: begin
        la = lv_r[0]; lb = lv_r[1]; lt = fade_r[1];
      end
      3'd5: begin
        la = lv_r[2]; lb = lv_r[3]; lt = fade_r[1];
      end
      3'd6: begin
        la = lv_r[4]; lb = lv_r[5]; lt = fade_r[2];
      end
      default: begin
        la = grad(gha, x0, ly, lz);
        lb = grad(ghb, x1, ly, lz);
        lt = fade_r[0];
      end
    endcase
    ldiff = (LW+1)'(lb) - (LW+1)'(la);
    lsum  = (LW+1)'(la) + mul_res[LW:0];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_FADE: begin
        mul_a = MW'(fade_op);
        mul_b = MW'(tsel);
      end
      ST_LERP: begin
        mul_a = MW'(lt);
        mul_b = MW'(ldiff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // table read address for the current hash step
  logic [7:0] hash_addr, hash_base;
  always_comb begin
    case (hs_r)
      4'd0:    hash_addr = ix;
      4'd1:    hash_addr = ix + 8'd1;
      4'd2:    hash_addr = ha_r;
      4'd3:    hash_addr = ha_r + 8'd1;
      4'd4:    hash_addr = hb_r;
      4'd5:    hash_addr = hb_r + 8'd1;
      4'd6:    hash_addr = haa_r;
      4'd7:    hash_addr = hba_r;
      4'd8:    hash_addr = hab_r;
      4'd9:    hash_addr = hbb_r;
      4'd10:   hash_addr = haa_r + 8'd1;
      4'd11:   hash_addr = hba_r + 8'd1;
      4'd12:   hash_addr = hab_r + 8'd1;
      default: hash_addr = hbb_r + 8'd1;
    endcase
    hash_base = (hs_r < 4'd2) ? iy : iz;
  end

  // octave accumulate
  logic [OW-1:0]        shamt;
  logic signed [SW-1:0] biased, term, sum_new;
  assign shamt   = oct_r + OW'(1);
  assign biased  = SW'(noise_r) + SW'(ONE_T);
  assign term    = biased >>> shamt;
  assign sum_new = sum_r + term;

  // datapath and output next values
  always_comb begin
    fa_nxt = fa_r;
    fs_nxt = fs_r;
    hs_nxt = hs_r;
    lk_nxt = lk_r;
    oct_nxt = oct_r;
    noct_nxt = noct_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    acc_nxt = acc_r;
    fade_nxt = fade_r;
    ha_nxt = ha_r;
    hb_nxt = hb_r;
    haa_nxt = haa_r;
    hab_nxt = hab_r;
    hba_nxt = hba_r;
    hbb_nxt = hbb_r;
    gh_nxt = gh_r;
    lv_nxt = lv_r;
    noise_nxt = noise_r;
    sum_nxt = sum_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt = out_sum_r;
    mem_req.we = 1'b0;
    mem_req.waddr = in_table_index;
    mem_req.wdata = in_table_value;
    mem_req.raddr = hash_addr;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // latch coordinates and clear the sequence counters
          cx_nxt = in_coord_x;
          cy_nxt = in_coord_y;
          cz_nxt = in_coord_z;
          noct_nxt = noct_in;
          oct_nxt = '0;
          fa_nxt = '0;
          fs_nxt = '0;
          hs_nxt = '0;
          lk_nxt = '0;
          sum_nxt = '0;
          if (!in_mode) begin
            mem_req.we = 1'b1;
            out_valid_nxt = 1'b1;
            out_sum_nxt = '0;
          end else if (noct_in == '0) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt = '0;
          end
        end
      end
      ST_FADE: begin
        acc_nxt = fade_e;
        fs_nxt = fs_r + 2'd1;
        if (fs_r == FADE_LAST_STEP) begin
          fade_nxt[fa_r] = (fade_e > AW'(ONE_T)) ? ONE_T : fade_e[FRAC_BITS:0];
          fa_nxt = (fa_r == AXIS_LAST) ? 2'd0 : fa_r + 2'd1;
        end
      end
      ST_HASH_WB: begin
        case (hs_r)
          4'd0:    ha_nxt  = mem_rdata + hash_base;
          4'd1:    hb_nxt  = mem_rdata + hash_base;
          4'd2:    haa_nxt = mem_rdata + hash_base;
          4'd3:    hab_nxt = mem_rdata + hash_base;
          4'd4:    hba_nxt = mem_rdata + hash_base;
          4'd5:    hbb_nxt = mem_rdata + hash_base;
          default: gh_nxt[3'(hs_r - HASH_GRAD_FIRST)] = mem_rdata;
        endcase
        hs_nxt = (hs_r == HASH_LAST) ? 4'd0 : hs_r + 4'd1;
      end
      ST_LERP: begin
        if (lk_r == LERP_LAST) begin
          noise_nxt = lsum[LW-1:0];
          lk_nxt = 3'd0;
        end else begin
          lv_nxt[lk_r] = lsum[LW-1:0];
          lk_nxt = lk_r + 3'd1;
        end
      end
      ST_ACC: begin
        sum_nxt = sum_new;
        oct_nxt = oct_r + OW'(1);
        cx_nxt = cx_r << 1;
        cy_nxt = cy_r << 1;
        cz_nxt = cz_r << 1;
        if (oct_r + OW'(1) == noct_r) begin
          // saturate the final sum into Q1.FRAC_BITS
          out_valid_nxt = 1'b1;
          if (sum_new < 0) begin
            out_sum_nxt = '0;
          end else if (sum_new > SUM_MAX) begin
            out_sum_nxt = SUM_MAX[FRAC_BITS:0];
          end else begin
            out_sum_nxt = sum_new[FRAC_BITS:0];
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      fa_r <= '0;
      fs_r <= '0;
      hs_r <= '0;
      lk_r <= '0;
      oct_r <= '0;
      noct_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fa_r <= fa_nxt;
      fs_r <= fs_nxt;
      hs_r <= hs_nxt;
      lk_r <= lk_nxt;
      oct_r <= oct_nxt;
      noct_r <= noct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    acc_r <= acc_nxt;
    fade_r <= fade_nxt;
    ha_r <= ha_nxt;
    hb_r <= hb_nxt;
    haa_r <= haa_nxt;
    hab_r <= hab_nxt;
    hba_r <= hba_nxt;
    hbb_r <= hbb_nxt;
    gh_r <= gh_nxt;
    lv_r <= lv_nxt;
    noise_r <= noise_nxt;
    sum_r <= sum_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_noise_sum = out_sum_r;

endmodule

// ----- hdl/pn3_checker.sv -----
`include "perlin_noise_3d_octaves_assert.svh"

module pn3_checker
  import pn3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   in_mode,
  input logic [3:0]             in_octave_count,
  input logic                   out_valid,
  input logic [FRAC_BITS:0]     out_noise_sum
);

  logic take_load, take_zero, take_eval, zero_out;
  assign take_load = start && !busy && !in_mode;
  assign take_zero = start && !busy && in_mode && (in_octave_count == 4'd0);
  assign take_eval = start && !busy && in_mode && (in_octave_count != 4'd0);
  assign zero_out  = out_valid && (out_noise_sum == '0);

  // a load item answers zero in the next cycle
  `PN3_ASSERT_NEXT(a_load_result, take_load, zero_out, "load item result")
  // zero octaves answers zero in the next cycle
  `PN3_ASSERT_NEXT(a_zero_oct, take_zero, zero_out, "zero octave result")
  // an evaluation keeps the block busy with no early result
  `PN3_ASSERT_NEXT(a_eval_busy, take_eval, busy && !out_valid, "evaluation not busy")
  // a result is shown only while idle
  `PN3_ASSERT_NOW(a_valid_idle, out_valid, !busy, "result while busy")

endmodule

bind perlin_noise_3d_octaves pn3_checker #(.FRAC_BITS(FRAC_BITS)) u_pn3_checker (.*);
